### hdl/mlfq_pkg.sv
// shared types, constants and helpers for the three-level feedback queue scheduler
// depends on nothing; imported by every module of the block
`default_nettype none

package mlfq_pkg;

    // queue sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int LEVELS      = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int LVL_W       = 2;
    localparam int ADDR_W      = LVL_W + PTR_W;
    localparam int MEM_DEPTH   = LEVELS * (1 << PTR_W);

    // field widths
    localparam int ID_W     = 8;
    localparam int BURST_W  = 16;
    localparam int ENTRY_W  = ID_W + BURST_W;
    localparam int SLICE_W  = 8;
    localparam int TIME_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;

    // level codes
    localparam logic [LVL_W-1:0] LVL_ZERO = 2'd0;
    localparam logic [LVL_W-1:0] LVL_ONE  = 2'd1;
    localparam logic [LVL_W-1:0] LVL_TWO  = 2'd2;

    // action codes
    localparam logic ACT_ADMIT    = 1'b0;
    localparam logic ACT_DISPATCH = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ADMITTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FINISHED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DEMOTED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_ZERO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_ONE  = 2'd1;

    // configuration reset values
    localparam logic [SLICE_W-1:0] SLICE_ZERO_RST = 8'd4;
    localparam logic [SLICE_W-1:0] SLICE_ONE_RST  = 8'd8;

    typedef struct packed {
        logic [SLICE_W-1:0] slice_zero;
        logic [SLICE_W-1:0] slice_one;
    } cfg_t;

    // request from the controller to the queue store
    typedef struct packed {
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic [ENTRY_W-1:0] wr_data;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
    } mem_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     served_id;
        logic [LVL_W-1:0]    served_level;
        logic [BURST_W-1:0]  run_amount;
        logic [TIME_W-1:0]   time_now;
    } res_t;

    // ring pointer advance with wrap at the queue depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/mlfq_store.sv
// queue entry store: all three level fifos in one synchronous memory
// one write and one registered read per cycle; depends on mlfq_pkg
`default_nettype none

module mlfq_store (
    input  wire logic                      clk,
    input  wire mlfq_pkg::mem_req_t        req,
    output logic [mlfq_pkg::ENTRY_W-1:0]   rd_data
);
    import mlfq_pkg::*;

    logic [ENTRY_W-1:0] mem [MEM_DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            rd_data <= mem[req.rd_addr];
    end

endmodule

`default_nettype wire

### hdl/mlfq_ctrl.sv
// scheduling controller: ring pointers, counts, time and the read-modify-write sequence
// drives the queue store; depends on mlfq_pkg
`default_nettype none

module mlfq_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        action,
    input  wire logic [mlfq_pkg::ID_W-1:0]   task_id,
    input  wire logic [mlfq_pkg::BURST_W-1:0] burst,
    input  wire mlfq_pkg::cfg_t              cfg,
    output mlfq_pkg::mem_req_t               mem_req,
    input  wire logic [mlfq_pkg::ENTRY_W-1:0] rd_data,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output mlfq_pkg::res_t                   res
);
    import mlfq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        state_reg,  state_next;
    logic [PTR_W-1:0]  head_reg    [LEVELS];
    logic [PTR_W-1:0]  head_next   [LEVELS];
    logic [PTR_W-1:0]  tail_reg    [LEVELS];
    logic [PTR_W-1:0]  tail_next   [LEVELS];
    logic [CNT_W-1:0]  count_reg   [LEVELS];
    logic [CNT_W-1:0]  count_next  [LEVELS];
    logic [CNT_W-1:0]  live_reg,   live_next;
    logic [TIME_W-1:0] time_reg,   time_next;
    logic [LVL_W-1:0]  sel_lvl_reg, sel_lvl_next;
    res_t              res_reg,    res_next;

    logic [LVL_W-1:0]   pick_lvl;
    logic               any_ready;
    logic [LVL_W-1:0]   push_lvl;
    logic [BURST_W-1:0] rem;
    logic [BURST_W-1:0] slice_ext;
    logic [BURST_W-1:0] run;
    logic [BURST_W-1:0] rem_left;

    // strict priority pick over the level counts
    always_comb
    begin
        any_ready = 1'b1;
        if (count_reg[0] != '0)
            pick_lvl = LVL_ZERO;
        else if (count_reg[1] != '0)
            pick_lvl = LVL_ONE;
        else
        begin
            pick_lvl  = LVL_TWO;
            any_ready = (count_reg[2] != '0);
        end
    end

    // run length of the head entry read last cycle
    always_comb
    begin
        rem       = rd_data[BURST_W-1:0];
        slice_ext = (sel_lvl_reg == LVL_ZERO) ? {{(BURST_W-SLICE_W){1'b0}}, cfg.slice_zero}
                                              : {{(BURST_W-SLICE_W){1'b0}}, cfg.slice_one};
        if (sel_lvl_reg == LVL_TWO)
            run = rem;
        else
            run = (rem < slice_ext) ? rem : slice_ext;
        rem_left = rem - run;
        push_lvl = (sel_lvl_reg == LVL_TWO) ? LVL_TWO : sel_lvl_reg + LVL_W'(1);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        live_next    = live_reg;
        time_next    = time_reg;
        sel_lvl_next = sel_lvl_reg;
        res_next     = res_reg;
        mem_req      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    if (action == ACT_ADMIT)
                    begin
                        res_next.time_now = time_reg;
                        if (live_reg >= CNT_W'(QUEUE_DEPTH))
                            res_next.status = ST_REFUSED;
                        else
                        begin
                            mem_req.wr_en   = 1'b1;
                            mem_req.wr_addr = {LVL_ZERO, tail_reg[0]};
                            mem_req.wr_data = {task_id, burst};
                            tail_next[0]    = ptr_inc(tail_reg[0]);
                            count_next[0]   = count_reg[0] + CNT_W'(1);
                            live_next       = live_reg + CNT_W'(1);
                            res_next.status = ST_ADMITTED;
                        end
                        state_next = S_EMIT;
                    end
                    else if (!any_ready)
                    begin
                        time_next         = time_reg + TIME_W'(1);
                        res_next.status   = ST_IDLE;
                        res_next.time_now = time_reg + TIME_W'(1);
                        state_next        = S_EMIT;
                    end
                    else
                    begin
                        // pop the head now, its entry arrives next cycle
                        mem_req.rd_en       = 1'b1;
                        mem_req.rd_addr     = {pick_lvl, head_reg[pick_lvl]};
                        head_next[pick_lvl] = ptr_inc(head_reg[pick_lvl]);
                        count_next[pick_lvl] = count_reg[pick_lvl] - CNT_W'(1);
                        sel_lvl_next        = pick_lvl;
                        state_next          = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                time_next             = time_reg + {{(TIME_W-BURST_W){1'b0}}, run};
                res_next.served_id    = rd_data[ENTRY_W-1:BURST_W];
                res_next.served_level = sel_lvl_reg;
                res_next.run_amount   = run;
                res_next.time_now     = time_reg + {{(TIME_W-BURST_W){1'b0}}, run};
                if (rem_left == '0)
                begin
                    if (live_reg != '0)
                        live_next = live_reg - CNT_W'(1);
                    res_next.status = ST_FINISHED;
                end
                else
                begin
                    // demote to the next level
                    mem_req.wr_en       = 1'b1;
                    mem_req.wr_addr     = {push_lvl, tail_reg[push_lvl]};
                    mem_req.wr_data     = {rd_data[ENTRY_W-1:BURST_W], rem_left};
                    tail_next[push_lvl] = ptr_inc(tail_reg[push_lvl]);
                    count_next[push_lvl] = count_reg[push_lvl] + CNT_W'(1);
                    res_next.status     = ST_DEMOTED;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            time_reg  <= '0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            time_reg  <= time_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // result payload and served level
    always_ff @(posedge clk)
    begin
        res_reg     <= res_next;
        sel_lvl_reg <= sel_lvl_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

endmodule

`default_nettype wire

### hdl/three_level_feedback_queue_scheduler.sv
// Three-level feedback queue scheduler.
// Input channel (in_valid / in_stall): one item per transfer, action selects
// admit (task_id, burst to the tail of level 0, unless 16 tasks are live) or
// dispatch (serve the first non-empty level's head, demote it if time is left).
// Output channel (out_valid / out_stall): exactly one result per input item,
// in order: status, served_id, served_level, run_amount, time_now.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets the
// level-0 slice, index 1 the level-1 slice; other indexes are ignored.
// Write it only while no item is in flight.
// An admit or idle dispatch passes its result from the controller's result
// register to the output register; a dispatch that runs a task first reads
// its entry from the queue memory. One item at a time: the next item is
// taken once the result has been handed to the output register.
// Reset empties all queues, clears time and restores slices to 4 and 8.
// While the receiver stalls, the result holds in the output register, the
// next item is still taken and its result waits in the controller.
`default_nettype none

module three_level_feedback_queue_scheduler (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              action,
    input  wire logic [mlfq_pkg::ID_W-1:0]         task_id,
    input  wire logic [mlfq_pkg::BURST_W-1:0]      burst,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [mlfq_pkg::STATUS_W-1:0]          status,
    output logic [mlfq_pkg::ID_W-1:0]              served_id,
    output logic [mlfq_pkg::LVL_W-1:0]             served_level,
    output logic [mlfq_pkg::BURST_W-1:0]           run_amount,
    output logic [mlfq_pkg::TIME_W-1:0]            time_now,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mlfq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mlfq_pkg::SLICE_W-1:0]      cfg_data
);
    import mlfq_pkg::*;

    cfg_t               cfg_reg;
    mem_req_t           mem_req;
    logic [ENTRY_W-1:0] rd_data;
    logic               res_valid;
    logic               res_ready;
    res_t               res;
    logic               out_valid_reg;
    res_t               out_res_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slice_zero <= SLICE_ZERO_RST;
            cfg_reg.slice_one  <= SLICE_ONE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SLICE_ZERO: cfg_reg.slice_zero <= cfg_data;
                REG_SLICE_ONE:  cfg_reg.slice_one  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    mlfq_store u_store (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    mlfq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .task_id   (task_id),
        .burst     (burst),
        .cfg       (cfg_reg),
        .mem_req   (mem_req),
        .rd_data   (rd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register, loads whenever it is empty or being drained
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_ready)
            out_valid_reg <= res_valid;
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
            out_res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_res_reg.status;
    assign served_id    = out_res_reg.served_id;
    assign served_level = out_res_reg.served_level;
    assign run_amount   = out_res_reg.run_amount;
    assign time_now     = out_res_reg.time_now;

endmodule

`default_nettype wire

### hdl/mlfq_checker.sv
// port-level checks for the three-level feedback queue scheduler
// bound to the top level; depends on mlfq_pkg
`default_nettype none

module mlfq_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [mlfq_pkg::STATUS_W-1:0]   status,
    input  wire logic [mlfq_pkg::ID_W-1:0]       served_id,
    input  wire logic [mlfq_pkg::LVL_W-1:0]      served_level,
    input  wire logic [mlfq_pkg::BURST_W-1:0]    run_amount,
    input  wire logic [mlfq_pkg::TIME_W-1:0]     time_now
);
    import mlfq_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(time_now)
            && $stable(served_id) && $stable(run_amount))
        else $error("stalled result changed");

    // one item at a time: the cycle after a transfer in, the input stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in flight");

    // admit and idle results carry no served task
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_ADMITTED || status == ST_REFUSED || status == ST_IDLE)
            |-> served_id == '0 && served_level == '0 && run_amount == '0)
        else $error("non-serving result carries task fields");

    // level two always runs to completion
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DEMOTED |-> served_level != LVL_TWO)
        else $error("task demoted from the lowest level");

endmodule

bind three_level_feedback_queue_scheduler mlfq_checker u_mlfq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .served_id    (served_id),
    .served_level (served_level),
    .run_amount   (run_amount),
    .time_now     (time_now)
);

`default_nettype wire
